// ----- rtl/aqrr_pkg.sv -----
`timescale 1ns / 1ps

package aqrr_pkg;

    localparam int AQRR_TABLE_DEPTH = 64;
    localparam int AQRR_TIME_BITS   = 16;

    localparam int TASK_W     = 6;
    localparam int FIELD_W    = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;

    localparam int STEP_W = 4;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t ST_IDLE     = 4'd0;
    localparam step_t ST_SUM      = 4'd1;
    localparam step_t ST_SUM_END  = 4'd2;
    localparam step_t ST_DIV_INIT = 4'd3;
    localparam step_t ST_DIV      = 4'd4;
    localparam step_t ST_SL_RD    = 4'd5;
    localparam step_t ST_SL_EMIT  = 4'd6;
    localparam step_t ST_DONE     = 4'd7;
    localparam step_t ST_EMPTY    = 4'd8;

    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_NO_DISP,
        C_NOT_LAST,
        C_CNT_ZERO,
        C_DIV_BUSY
    } cond_t;

    typedef struct packed {
        logic  ready;
        logic  rd_en;
        logic  acc;
        logic  clr_acc;
        logic  clr_idx;
        logic  idx_inc;
        logic  div_init;
        logic  div_step;
        logic  slice;
        logic  emit_idle;
        logic  hold_en;
        cond_t cond;
        step_t target;
    } cw_t;

    typedef struct packed {
        logic dispatch;
        logic idx_last;
        logic cnt_zero;
        logic div_busy;
        logic hold;
    } stat_t;

    function automatic cw_t ucode_rom(input step_t s);
        cw_t w;
        w = '0;
        w.cond = C_NEXT;
        w.target = ST_IDLE;
        case (s)
            ST_IDLE:
            begin
                w.ready   = 1'b1;
                w.clr_acc = 1'b1;
                w.clr_idx = 1'b1;
                w.cond    = C_NO_DISP;
                w.target  = ST_IDLE;
            end
            ST_SUM:
            begin
                w.rd_en   = 1'b1;
                w.acc     = 1'b1;
                w.idx_inc = 1'b1;
                w.cond    = C_NOT_LAST;
                w.target  = ST_SUM;
            end
            ST_SUM_END:
            begin
                w.acc = 1'b1;
            end
            ST_DIV_INIT:
            begin
                w.div_init = 1'b1;
                w.clr_idx  = 1'b1;
                w.cond     = C_CNT_ZERO;
                w.target   = ST_EMPTY;
            end
            ST_DIV:
            begin
                w.div_step = 1'b1;
                w.cond     = C_DIV_BUSY;
                w.target   = ST_DIV;
            end
            ST_SL_RD:
            begin
                w.rd_en = 1'b1;
            end
            ST_SL_EMIT:
            begin
                w.slice   = 1'b1;
                w.idx_inc = 1'b1;
                w.hold_en = 1'b1;
                w.cond    = C_NOT_LAST;
                w.target  = ST_SL_RD;
            end
            ST_DONE:
            begin
                w.cond   = C_JUMP;
                w.target = ST_IDLE;
            end
            ST_EMPTY:
            begin
                w.emit_idle = 1'b1;
                w.hold_en   = 1'b1;
                w.cond      = C_JUMP;
                w.target    = ST_IDLE;
            end
            default:
            begin
                w.cond   = C_JUMP;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/aqrr_ram.sv -----
`timescale 1ns / 1ps

module aqrr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/aqrr_seq.sv -----
`timescale 1ns / 1ps

module aqrr_seq
    import aqrr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t st,
    output cw_t   cw
);

    step_t step_reg;
    step_t step_next;
    logic  take;

    assign cw = ucode_rom(step_reg);

    always_comb
    begin
        case (cw.cond)
            C_NEXT:     take = 1'b0;
            C_JUMP:     take = 1'b1;
            C_NO_DISP:  take = !st.dispatch;
            C_NOT_LAST: take = !st.idx_last;
            C_CNT_ZERO: take = st.cnt_zero;
            C_DIV_BUSY: take = st.div_busy;
            default:    take = 1'b1;
        endcase
        if (cw.hold_en && st.hold)
        begin
            step_next = step_reg;
        end
        else if (take)
        begin
            step_next = cw.target;
        end
        else
        begin
            step_next = step_reg + step_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- rtl/aqrr_dp.sv -----
`timescale 1ns / 1ps

module aqrr_dp
    import aqrr_pkg::*;
#(
    parameter int TABLE_DEPTH = AQRR_TABLE_DEPTH,
    parameter int TIME_BITS   = AQRR_TIME_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cw_t                   cw,
    output stat_t                 st,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);

    localparam int IDX_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W      = TIME_BITS + IDX_W;
    localparam int DCNT_W     = $clog2(SUM_W);
    localparam int TASK_CMP_W = TASK_W + 1;

    logic                 xfer_in;
    logic                 load;
    logic [TASK_W-1:0]    in_task;
    logic [FIELD_W-1:0]   in_time;
    logic [TIME_BITS-1:0] rdata;
    logic [TIME_BITS-1:0] ent;
    logic [TIME_BITS-1:0] q;
    logic [TIME_BITS-1:0] grant;
    logic [TIME_BITS-1:0] left;
    logic                 active;
    logic                 out_free;
    logic                 hold;
    logic                 advance;
    logic                 do_slice;
    logic                 do_empty;
    logic                 acc_hit;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [TIME_BITS-1:0] ram_wdata;
    logic [CNT_W:0]       trial;

    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       pipe_idx_reg, pipe_idx_next;
    logic                   pipe_vld_reg, pipe_vld_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       n_reg, n_next;
    logic [CNT_W-1:0]       rem_reg, rem_next;
    logic [DCNT_W-1:0]      dcnt_reg, dcnt_next;
    logic                   out_vld_reg, out_vld_next;
    logic [TASK_W-1:0]      task_reg, task_next;
    logic [FIELD_W-1:0]     grant_reg, grant_next;
    logic [FIELD_W-1:0]     left_reg, left_next;
    logic                   fin_reg, fin_next;
    logic [FIELD_W-1:0]     quant_reg, quant_next;
    logic                   sval_reg, sval_next;
    logic                   last_reg, last_next;

    assign s_tready = cw.ready;
    assign in_task  = s_tdata[TASK_W-1:0];
    assign in_time  = s_tdata[TASK_W+FIELD_W-1:TASK_W];
    assign xfer_in  = s_tvalid && cw.ready;
    assign load     = xfer_in && !s_tuser
                      && ({1'b0, in_task} < TASK_CMP_W'(TABLE_DEPTH));

    assign ent      = valid_reg[idx_reg] ? rdata : '0;
    assign active   = (ent != '0);
    assign q        = sum_reg[TIME_BITS-1:0];
    assign grant    = (ent <= q) ? ent : q;
    assign left     = ent - grant;
    assign out_free = !out_vld_reg || m_tready;
    assign hold     = ((cw.slice && active) || cw.emit_idle) && !out_free;
    assign advance  = !(cw.hold_en && hold);
    assign do_slice = cw.slice && active && advance;
    assign do_empty = cw.emit_idle && advance;
    assign acc_hit  = cw.acc && pipe_vld_reg && valid_reg[pipe_idx_reg] && (rdata != '0);
    assign trial    = {rem_reg, sum_reg[SUM_W-1]};

    assign ram_we    = load || do_slice;
    assign ram_waddr = load ? in_task[IDX_W-1:0] : idx_reg;
    assign ram_wdata = load ? TIME_BITS'(in_time) : left;

    aqrr_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    assign st.dispatch = xfer_in && s_tuser;
    assign st.idx_last = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign st.cnt_zero = (cnt_reg == '0);
    assign st.div_busy = (dcnt_reg != '0);
    assign st.hold     = hold;

    always_comb
    begin
        valid_next    = valid_reg;
        idx_next      = idx_reg;
        pipe_idx_next = idx_reg;
        pipe_vld_next = cw.rd_en && cw.acc;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        n_next        = n_reg;
        rem_next      = rem_reg;
        dcnt_next     = dcnt_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        task_next     = task_reg;
        grant_next    = grant_reg;
        left_next     = left_reg;
        fin_next      = fin_reg;
        quant_next    = quant_reg;
        sval_next     = sval_reg;
        last_next     = last_reg;

        if (load)
        begin
            valid_next[in_task[IDX_W-1:0]] = 1'b1;
        end
        if (cw.clr_acc)
        begin
            sum_next = '0;
            cnt_next = '0;
            n_next   = '0;
        end
        if (cw.clr_idx)
        begin
            idx_next = '0;
        end
        if (cw.idx_inc && advance)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
        if (acc_hit)
        begin
            sum_next = sum_reg + SUM_W'(rdata);
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cw.div_init)
        begin
            rem_next  = '0;
            dcnt_next = DCNT_W'(SUM_W - 1);
        end
        if (cw.div_step)
        begin
            if (trial >= {1'b0, cnt_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, cnt_reg});
                sum_next = {sum_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
                sum_next = {sum_reg[SUM_W-2:0], 1'b0};
            end
            dcnt_next = dcnt_reg - DCNT_W'(1);
        end
        if (do_slice)
        begin
            out_vld_next = 1'b1;
            task_next    = TASK_W'(idx_reg);
            grant_next   = FIELD_W'(grant);
            left_next    = FIELD_W'(left);
            fin_next     = (left == '0);
            quant_next   = FIELD_W'(q);
            sval_next    = 1'b1;
            last_next    = ((n_reg + CNT_W'(1)) == cnt_reg);
            n_next       = n_reg + CNT_W'(1);
        end
        if (do_empty)
        begin
            out_vld_next = 1'b1;
            task_next    = '0;
            grant_next   = '0;
            left_next    = '0;
            fin_next     = 1'b0;
            quant_next   = FIELD_W'(1);
            sval_next    = 1'b0;
            last_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            idx_reg      <= '0;
            pipe_vld_reg <= 1'b0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
            n_reg        <= '0;
            dcnt_reg     <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            idx_reg      <= idx_next;
            pipe_vld_reg <= pipe_vld_next;
            sum_reg      <= sum_next;
            cnt_reg      <= cnt_next;
            n_reg        <= n_next;
            dcnt_reg     <= dcnt_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_idx_reg <= pipe_idx_next;
        rem_reg      <= rem_next;
        task_reg     <= task_next;
        grant_reg    <= grant_next;
        left_reg     <= left_next;
        fin_reg      <= fin_next;
        quant_reg    <= quant_next;
        sval_reg     <= sval_next;
        last_reg     <= last_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, quant_reg, fin_reg, left_reg, grant_reg, task_reg};
    assign m_tuser  = sval_reg;
    assign m_tlast  = last_reg;

endmodule

// ----- rtl/average_quantum_round_robin_top.sv -----
`timescale 1ns / 1ps
// Round-robin dispatcher with a quantum equal to the average remaining time.
// Input stream (s_*): tuser = opcode, tdata = task_id and run_time.
//   A load writes one entry of the remaining-time table. A dispatch
//   produces one transfer per active task on m_*, in task order, with
//   tlast on the final one; an idle table gives one empty transfer
//   (tuser low, quantum 1).
// Output stream (m_*): tuser = slice_valid, tlast = last, tdata holds the
//   slice fields. A single output register holds a result while the receiver
//   stalls; the sequencer waits on that step and resumes when it drains.
// Dispatch steps: a sum pass over the table, a bit-serial divide of the sum
// by the count of active tasks, then a slice pass that reads and updates
// each table entry in turn. The single table port sets the pace of both
// passes.
// Only one item is in work at a time; s_tready is high only between rounds.
// Reset clears every table entry to inactive through per-entry valid flops
// and empties the output register; no clearing pass is needed.
module average_quantum_round_robin_top
    import aqrr_pkg::*;
#(
    parameter int TABLE_DEPTH = AQRR_TABLE_DEPTH,
    parameter int TIME_BITS   = AQRR_TIME_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // task_id[5:0], run_time[21:6], zero pad
    input  logic                  s_tuser,   // opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // slice_task[5:0], granted_time[21:6],
                                             // time_left[37:22], finished[38],
                                             // quantum[54:39], zero pad
    output logic                  m_tuser,   // slice_valid
    output logic                  m_tlast
);

    cw_t   cw;
    stat_t st;

    aqrr_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cw    (cw)
    );

    aqrr_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cw       (cw),
        .st       (st),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
